// ===== hdl/slifo_pkg.sv =====
package slifo_pkg;

	localparam int DATA_W    = 32;
	localparam int REQ_W     = 3;
	localparam int ST_W      = 2;
	localparam int POS_W     = 5;
	localparam int OCC_W     = 5;
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 48;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_COUNT   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SEARCH  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SWAP    = 3'd6;
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd7;

	// status codes
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

	// operation broadcast to every cell of the row
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP,
		CELL_ROT,
		CELL_DEL,
		CELL_SWAP
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   a;
		logic [DATA_W-1:0]   b;
	} cell_cmd_t;

endpackage

// ===== hdl/slifo_cell.sv =====
module slifo_cell #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic                         clk,
	input  slifo_pkg::cell_cmd_t         cmd,
	input  logic [IW-1:0]                p_idx,
	input  logic [IW-1:0]                ka_idx,
	input  logic [IW-1:0]                kb_idx,
	input  logic [slifo_pkg::DATA_W-1:0] prev_d,
	input  logic [slifo_pkg::DATA_W-1:0] next_d,
	input  logic [slifo_pkg::DATA_W-1:0] top_d,
	output logic [slifo_pkg::DATA_W-1:0] q
);
	import slifo_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [DATA_W-1:0] entry_q;

	// cell IDX holds the entry IDX places below the top
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_HOLD: begin
			end
			CELL_PUSH: begin
				entry_q <= (IDX == 0) ? cmd.a : prev_d;
			end
			CELL_POP: begin
				entry_q <= next_d;
			end
			CELL_ROT: begin
				// move the top word down to slot p, lift everything above it
				if (MY_IDX < p_idx) begin
					entry_q <= next_d;
				end else if (MY_IDX == p_idx) begin
					entry_q <= top_d;
				end
			end
			CELL_DEL: begin
				if (MY_IDX >= p_idx) begin
					entry_q <= next_d;
				end
			end
			CELL_SWAP: begin
				if (MY_IDX == ka_idx) begin
					entry_q <= cmd.b;
				end else if (MY_IDX == kb_idx) begin
					entry_q <= cmd.a;
				end
			end
			default: begin
			end
		endcase
	end

	assign q = entry_q;

endmodule

// ===== hdl/slifo_seq.sv =====
module slifo_seq #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic [slifo_pkg::REQ_W-1:0]                 req,
	input  logic [slifo_pkg::DATA_W-1:0]                a,
	input  logic [slifo_pkg::DATA_W-1:0]                b,
	input  logic [slifo_pkg::DATA_W-1:0]                top_d,
	output slifo_pkg::cell_cmd_t                        cmd,
	output logic [$clog2(STACK_DEPTH)-1:0]              p_idx,
	output logic [$clog2(STACK_DEPTH)-1:0]              ka_idx,
	output logic [$clog2(STACK_DEPTH)-1:0]              kb_idx,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic [slifo_pkg::ST_W-1:0]                  status,
	output logic [slifo_pkg::DATA_W-1:0]                data_out,
	output logic [slifo_pkg::POS_W-1:0]                 position,
	output logic [slifo_pkg::OCC_W-1:0]                 occupancy
);
	import slifo_pkg::*;

	localparam int IW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_REV  = 2'd2;
	localparam logic [1:0] S_FIX  = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     step_q;
	logic [REQ_W-1:0]  req_q;
	logic [DATA_W-1:0] a_q, b_q;
	logic [IW-1:0]     ka_q, kb_q;
	logic              fa_q, fb_q;

	logic              out_valid_q;
	logic [ST_W-1:0]   st_q, st_d;
	logic [DATA_W-1:0] data_q, data_d;
	logic [POS_W-1:0]  pos_q, pos_d;

	logic              slot_free, accept, load_out, start;
	logic [CW-1:0]     cnt_m1, rev_p;
	logic [IW:0]       ka_p1;
	logic              last_walk, last_rev;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign cnt_m1    = cnt_q - 1'b1;
	assign rev_p     = cnt_m1 - step_q;
	assign ka_p1     = {1'b0, ka_q} + 1'b1;
	assign last_walk = (step_q == cnt_m1);
	assign last_rev  = (step_q == cnt_q - CW'(2));

	always_comb begin
		cmd.op   = CELL_HOLD;
		cmd.a    = a_q;
		cmd.b    = b_q;
		p_idx    = cnt_m1[IW-1:0];
		state_d  = state_q;
		cnt_d    = cnt_q;
		load_out = 1'b0;
		start    = 1'b0;
		st_d     = ST_OK;
		data_d   = '0;
		pos_d    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					load_out = 1'b1;
					case (req)
						REQ_PUSH: begin
							if (cnt_q == FULL_CNT) begin
								st_d = ST_FULL;
							end else begin
								cmd.op = CELL_PUSH;
								cmd.a  = a;
								cnt_d  = cnt_q + 1'b1;
							end
						end
						REQ_POP: begin
							if (cnt_q == '0) begin
								st_d = ST_EMPTY;
							end else begin
								cmd.op = CELL_POP;
								data_d = top_d;
								cnt_d  = cnt_m1;
							end
						end
						REQ_COUNT: begin
						end
						REQ_CLEAR: begin
							cnt_d = '0;
						end
						REQ_REVERSE: begin
							if (cnt_q == '0) begin
								st_d = ST_EMPTY;
							end else if (cnt_q != CW'(1)) begin
								load_out = 1'b0;
								start    = 1'b1;
								state_d  = S_REV;
							end
						end
						default: begin
							// search, delete, swap: equal swap values are a no-op
							if (req == REQ_SWAP && a == b) begin
							end else if (cnt_q == '0) begin
								st_d = ST_EMPTY;
							end else begin
								load_out = 1'b0;
								start    = 1'b1;
								state_d  = S_WALK;
							end
						end
					endcase
				end
			end
			S_WALK: begin
				// one full rotation of the occupied cells restores the order
				cmd.op = CELL_ROT;
				p_idx  = cnt_m1[IW-1:0];
				if (last_walk) begin
					state_d = S_FIX;
				end
			end
			S_REV: begin
				cmd.op = CELL_ROT;
				p_idx  = rev_p[IW-1:0];
				if (last_rev) begin
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
					case (req_q)
						REQ_SEARCH: begin
							if (fa_q) begin
								pos_d = POS_W'(ka_p1);
							end else begin
								st_d = ST_MISSING;
							end
						end
						REQ_DELETE: begin
							if (fa_q) begin
								cmd.op = CELL_DEL;
								p_idx  = ka_q;
								cnt_d  = cnt_m1;
							end else begin
								st_d = ST_MISSING;
							end
						end
						REQ_SWAP: begin
							if (fa_q && fb_q) begin
								cmd.op = CELL_SWAP;
							end else begin
								st_d = ST_MISSING;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			fa_q        <= 1'b0;
			fb_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (start) begin
				step_q <= '0;
				fa_q   <= 1'b0;
				fb_q   <= 1'b0;
			end else if (state_q == S_WALK) begin
				step_q <= step_q + 1'b1;
				if (!fa_q && top_d == a_q) begin
					fa_q <= 1'b1;
				end
				if (!fb_q && top_d == b_q) begin
					fb_q <= 1'b1;
				end
			end else if (state_q == S_REV) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_q <= req;
			a_q   <= a;
			b_q   <= b;
		end
		// latch the first match from the top
		if (state_q == S_WALK) begin
			if (!fa_q && top_d == a_q) begin
				ka_q <= step_q[IW-1:0];
			end
			if (!fb_q && top_d == b_q) begin
				kb_q <= step_q[IW-1:0];
			end
		end
		if (load_out) begin
			st_q   <= st_d;
			data_q <= data_d;
			pos_q  <= pos_d;
		end
	end

	assign ka_idx    = ka_q;
	assign kb_idx    = kb_q;
	assign out_valid = out_valid_q;
	assign status    = st_q;
	assign data_out  = data_q;
	assign position  = pos_q;
	assign occupancy = OCC_W'(cnt_q);

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL_CNT)
		else $error("entry count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> step_q < cnt_q)
		else $error("walk ran past the occupied cells");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == REQ_PUSH && cnt_q != FULL_CNT |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("push did not grow the stack");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIX && slot_free |=> state_q == S_IDLE && out_valid_q)
		else $error("finished request did not post a word");

endmodule

// ===== hdl/searchable_lifo_stack.sv =====
// Push, pop, count, clear, equal-value swap and any request refused as full or empty: result word
// registered in the cycle after acceptance. Search, delete and swap: the walk rotates the
// occupied cells once, comparing one entry per cycle at the top cell, then commits the result.
// Reverse: occupancy - 1 rotation steps, then a commit; a single entry needs no rotation.
// One request at a time; the next word enters as the result leaves.
// Reset clears the entry count, the sequencer and the output valid; cell contents are kept.
module searchable_lifo_stack #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// value_a [31:0], value_b [63:32]
	input  logic [slifo_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// req_type [2:0]
	input  logic [slifo_pkg::REQ_W-1:0]     s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// data_out [31:0], position [36:32], occupancy [41:37], zero [47:42]
	output logic [slifo_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// status [1:0]
	output logic [slifo_pkg::ST_W-1:0]      m_axis_tuser
);
	import slifo_pkg::*;

	localparam int IW    = $clog2(STACK_DEPTH);
	localparam int PAD_W = M_TDATA_W - DATA_W - POS_W - OCC_W;

	logic [DATA_W-1:0] cell_q [STACK_DEPTH];
	logic [DATA_W-1:0] prev_d [STACK_DEPTH];
	logic [DATA_W-1:0] next_d [STACK_DEPTH];

	cell_cmd_t         cmd;
	logic [IW-1:0]     p_idx, ka_idx, kb_idx;
	logic [DATA_W-1:0] data_out;
	logic [POS_W-1:0]  position;
	logic [OCC_W-1:0]  occupancy;

	slifo_seq #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.req       (s_axis_tuser),
		.a         (s_axis_tdata[DATA_W-1:0]),
		.b         (s_axis_tdata[2*DATA_W-1:DATA_W]),
		.top_d     (cell_q[0]),
		.cmd       (cmd),
		.p_idx     (p_idx),
		.ka_idx    (ka_idx),
		.kb_idx    (kb_idx),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (m_axis_tuser),
		.data_out  (data_out),
		.position  (position),
		.occupancy (occupancy)
	);

	for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
		if (gi == 0) begin : g_first
			assign prev_d[gi] = '0;
		end else begin : g_inner_prev
			assign prev_d[gi] = cell_q[gi-1];
		end
		if (gi == STACK_DEPTH - 1) begin : g_last
			assign next_d[gi] = '0;
		end else begin : g_inner_next
			assign next_d[gi] = cell_q[gi+1];
		end

		slifo_cell #(
			.IW  (IW),
			.IDX (gi)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.p_idx  (p_idx),
			.ka_idx (ka_idx),
			.kb_idx (kb_idx),
			.prev_d (prev_d[gi]),
			.next_d (next_d[gi]),
			.top_d  (cell_q[0]),
			.q      (cell_q[gi])
		);
	end

	assign m_axis_tdata = {{PAD_W{1'b0}}, occupancy, position, data_out};

endmodule

// ===== tb/searchable_lifo_stack_tb.sv =====
module searchable_lifo_stack_tb;
	import slifo_pkg::*;

	localparam int STACK_SLOTS = 16;
	localparam int RANDOM_ITEMS = 900;
	localparam int SEGMENT_LEN = 50;

	typedef struct {
		logic [REQ_W-1:0]  req;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} request_t;

	typedef struct {
		logic [ST_W-1:0]   st;
		logic [DATA_W-1:0] data;
		logic [POS_W-1:0]  pos;
		logic [OCC_W-1:0]  occ;
	} outcome_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// value_a [31:0], value_b [63:32]
	logic [S_TDATA_W-1:0]   s_axis_tdata;
	// req_type [2:0]
	logic [REQ_W-1:0]       s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// data_out [31:0], position [36:32], occupancy [41:37], zero [47:42]
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	// status [1:0]
	logic [ST_W-1:0]        m_axis_tuser;

	request_t pending_reqs[$];
	outcome_t expected_outcomes[$];

	// shadow copy of the stack
	logic [DATA_W-1:0] stack_mem [STACK_SLOTS];
	int held;

	logic [DATA_W-1:0] value_pool [8];
	int  errors;
	int  cyc;
	int  accepted;
	bit  word_taken;
	bit  hold_off;

	searchable_lifo_stack #(
		.STACK_DEPTH(STACK_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// index of the first match seen from the top, or -1
	function automatic int find_top(logic [DATA_W-1:0] v);
		int n;
		n = held;
		while (n > 0) begin
			n--;
			if (stack_mem[n] == v)
				return n;
		end
		return -1;
	endfunction

	function automatic outcome_t apply_request(request_t r);
		outcome_t o;
		int ia, ib, i, lo, hi;
		logic [DATA_W-1:0] t;
		o.st = ST_OK;
		o.data = '0;
		o.pos = '0;
		case (r.req)
			REQ_PUSH: begin
				if (held >= STACK_SLOTS) begin
					o.st = ST_FULL;
				end else begin
					stack_mem[held] = r.a;
					held++;
				end
			end
			REQ_POP: begin
				if (held == 0) begin
					o.st = ST_EMPTY;
				end else begin
					held--;
					o.data = stack_mem[held];
				end
			end
			REQ_COUNT: ;
			REQ_SEARCH: begin
				if (held == 0) begin
					o.st = ST_EMPTY;
				end else begin
					ia = find_top(r.a);
					if (ia < 0)
						o.st = ST_MISSING;
					else
						o.pos = POS_W'(held - ia);
				end
			end
			REQ_DELETE: begin
				if (held == 0) begin
					o.st = ST_EMPTY;
				end else begin
					ia = find_top(r.a);
					if (ia < 0) begin
						o.st = ST_MISSING;
					end else begin
						// close the gap above the match
						for (i = ia; i + 1 < held; i++)
							stack_mem[i] = stack_mem[i + 1];
						held--;
					end
				end
			end
			REQ_REVERSE: begin
				if (held == 0) begin
					o.st = ST_EMPTY;
				end else begin
					lo = 0;
					hi = held - 1;
					while (lo < hi) begin
						t = stack_mem[lo];
						stack_mem[lo] = stack_mem[hi];
						stack_mem[hi] = t;
						lo++;
						hi--;
					end
				end
			end
			REQ_SWAP: begin
				// equal values win over an empty store
				if (r.a != r.b) begin
					if (held == 0) begin
						o.st = ST_EMPTY;
					end else begin
						ia = find_top(r.a);
						ib = find_top(r.b);
						if (ia < 0 || ib < 0) begin
							o.st = ST_MISSING;
						end else begin
							t = stack_mem[ia];
							stack_mem[ia] = stack_mem[ib];
							stack_mem[ib] = t;
						end
					end
				end
			end
			REQ_CLEAR: held = 0;
			default: ;
		endcase
		o.occ = OCC_W'(held);
		return o;
	endfunction

	function automatic bit idle_now();
		if (cyc >= 2000 && cyc < 4000)
			return 1'b0;
		return $urandom_range(99) < 29;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(99) < 70)
			return value_pool[$urandom_range(7)];
		return $urandom;
	endfunction

	task automatic add_req(logic [REQ_W-1:0] req, logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		request_t r;
		r.req = req;
		r.a = a;
		r.b = b;
		pending_reqs.push_back(r);
	endtask

	task automatic check_field(string name, logic [DATA_W-1:0] want_v,
			logic [DATA_W-1:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	// driver: advance to the next word once the current one is taken
	always @(negedge clk) begin : drive
		request_t r;
		cyc++;
		if (arst_n && (!s_axis_tvalid || word_taken)) begin
			if (pending_reqs.size() > 0 && !idle_now()) begin
				r = pending_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {r.b, r.a};
				s_axis_tuser <= r.req;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		word_taken = 1'b0;
		m_axis_tready <= !hold_off && !idle_now();
	end

	// monitor: predict on every accepted request, check every result word
	always @(posedge clk) begin : watch
		request_t r;
		outcome_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				r.req = s_axis_tuser;
				r.a = s_axis_tdata[31:0];
				r.b = s_axis_tdata[63:32];
				expected_outcomes.push_back(apply_request(r));
				word_taken = 1'b1;
				accepted++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_outcomes.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %h status %0d",
						$time, m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					want = expected_outcomes.pop_front();
					check_field("status", DATA_W'(want.st), DATA_W'(m_axis_tuser));
					check_field("data_out", want.data, m_axis_tdata[31:0]);
					check_field("position", DATA_W'(want.pos), DATA_W'(m_axis_tdata[36:32]));
					check_field("occupancy", DATA_W'(want.occ), DATA_W'(m_axis_tdata[41:37]));
					check_field("padding", '0, DATA_W'(m_axis_tdata[47:42]));
				end
			end
		end
	end

	// hold the result side off long enough for the input to stall
	initial begin
		hold_off = 1'b0;
		while (accepted < 150)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int n, seg, pw, pp, roll, pick;
		logic [REQ_W-1:0] op;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_COUNT;
		m_axis_tready = 1'b0;
		errors = 0;
		cyc = 0;
		accepted = 0;
		word_taken = 1'b0;
		held = 0;
		for (n = 0; n < STACK_SLOTS; n++)
			stack_mem[n] = '0;

		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		for (n = 4; n < 8; n++)
			value_pool[n] = $urandom;

		// empty store: every request that can be refused
		add_req(REQ_CLEAR, 32'h0, 32'h0);
		add_req(REQ_POP, 32'h0, 32'h0);
		add_req(REQ_SEARCH, 32'h0, 32'h0);
		add_req(REQ_DELETE, 32'h0, 32'h0);
		add_req(REQ_REVERSE, 32'h0, 32'h0);
		add_req(REQ_SWAP, 32'h1, 32'h2);
		add_req(REQ_SWAP, 32'h5, 32'h5);
		// extremes, hits and misses
		add_req(REQ_PUSH, 32'h8000_0000, 32'hffff_ffff);
		add_req(REQ_PUSH, 32'h7fff_ffff, 32'h0);
		add_req(REQ_PUSH, 32'h0, 32'h8000_0000);
		add_req(REQ_PUSH, 32'hffff_ffff, 32'h7fff_ffff);
		add_req(REQ_SEARCH, 32'h7fff_ffff, 32'h0);
		add_req(REQ_SEARCH, 32'h1234_5678, 32'h0);
		add_req(REQ_DELETE, 32'h1234_5678, 32'h0);
		add_req(REQ_SWAP, 32'hffff_ffff, 32'h8000_0000);
		add_req(REQ_SWAP, 32'hffff_ffff, 32'h1234_5678);
		add_req(REQ_REVERSE, 32'h0, 32'h0);
		add_req(REQ_DELETE, 32'h0, 32'h0);
		add_req(REQ_POP, 32'h0, 32'h0);
		add_req(REQ_COUNT, 32'hffff_ffff, 32'hffff_ffff);

		// segments lean toward filling, draining, or a mix; start with a fill
		pw = 75;
		pp = 5;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n > 0 && n % SEGMENT_LEN == 0) begin
				seg = $urandom_range(2);
				case (seg)
					0: begin pw = 75; pp = 5; end
					1: begin pw = 15; pp = 35; end
					default: begin pw = 35; pp = 15; end
				endcase
			end
			roll = $urandom_range(99);
			if (roll < pw) begin
				op = REQ_PUSH;
			end else if (roll < pw + pp) begin
				op = REQ_POP;
			end else begin
				pick = $urandom_range(99);
				if (pick < 14)
					op = REQ_COUNT;
				else if (pick < 40)
					op = REQ_SEARCH;
				else if (pick < 62)
					op = REQ_DELETE;
				else if (pick < 74)
					op = REQ_REVERSE;
				else if (pick < 97)
					op = REQ_SWAP;
				else
					op = REQ_CLEAR;
			end
			add_req(op, pick_value(), pick_value());
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (errors == 0 && expected_outcomes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/slifo_pkg.sv
hdl/slifo_cell.sv
hdl/slifo_seq.sv
hdl/searchable_lifo_stack.sv
tb/searchable_lifo_stack_tb.sv
